[rtl/qts_pkg.sv]
// ----------------------------------------------------------------------------
// qts_pkg
// Types and constants shared by the quoted token splitter modules.
// ----------------------------------------------------------------------------
package qts_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned TOK_W           = 16;  // width of the reported token count
  localparam int unsigned MAX_RES         = 4;   // results one byte can cause
  localparam int unsigned RES_CNT_W       = 3;   // holds 0..MAX_RES

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_DQ     = 3'd2,
    MODE_DQ_ESC = 3'd3,
    MODE_SQ     = 3'd4,
    MODE_SKIP   = 3'd5
  } mode_e;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       ch;
    logic [TOK_W-1:0] cnt;
    logic             last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0]   ev;
    logic [RES_CNT_W-1:0] n;
  } batch_t;

endpackage

[rtl/qts_lexer.sv]
// ----------------------------------------------------------------------------
// qts_lexer
// Lexer state and the per-byte step: decodes one byte against the current
// mode and builds the batch of results that byte causes.
// ----------------------------------------------------------------------------
module qts_lexer import qts_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       commit_i,
  input  logic [7:0] char_i,
  input  logic       eol_i,
  output batch_t     batch_o
);

  mode_e                  mode_q, mode_d, mode_c;
  logic                   forced_q, forced_d, forced_c;
  logic                   nonempty_q, nonempty_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

  logic       add_a, add_b, flush_c;
  logic [7:0] byte_a, byte_b;
  batch_t     bat;

  function automatic logic [TOK_W-1:0] cnt_report(input logic [COUNT_WIDTH-1:0] c);
    if (COUNT_WIDTH > TOK_W && (c >> TOK_W) != '0) begin
      return '1;
    end
    return TOK_W'(c);
  endfunction

  // Character decode
  always_comb begin
    mode_c   = mode_q;
    forced_c = forced_q;
    add_a    = 1'b0;
    add_b    = 1'b0;
    byte_a   = char_i;
    byte_b   = char_i;
    flush_c  = 1'b0;
    if (char_i == CH_NUL) begin
      flush_c = (mode_q != MODE_SKIP);
      mode_c  = MODE_SKIP;
    end else begin
      unique case (mode_q)
        MODE_ESC: begin
          add_a  = 1'b1;
          mode_c = MODE_NORMAL;
        end
        MODE_DQ: begin
          if (char_i == CH_BSL) begin
            mode_c = MODE_DQ_ESC;
          end else if (char_i == CH_DQ) begin
            mode_c = MODE_NORMAL;
          end else begin
            add_a = 1'b1;
          end
        end
        MODE_DQ_ESC: begin
          // keep the backslash unless it escapes one of the special bytes
          if (char_i != CH_DOLLAR && char_i != CH_BSL && char_i != CH_DQ) begin
            add_a  = 1'b1;
            byte_a = CH_BSL;
            add_b  = 1'b1;
          end else begin
            add_a = 1'b1;
          end
          mode_c = MODE_DQ;
        end
        MODE_SQ: begin
          if (char_i == CH_SQ) begin
            mode_c = MODE_NORMAL;
          end else begin
            add_a = 1'b1;
          end
        end
        MODE_SKIP: begin
        end
        default: begin
          mode_c = MODE_NORMAL;
          if (char_i == CH_BSL) begin
            mode_c = MODE_ESC;
          end else if (char_i == CH_DQ) begin
            forced_c = 1'b1;
            mode_c   = MODE_DQ;
          end else if (char_i == CH_SQ) begin
            forced_c = 1'b1;
            mode_c   = MODE_SQ;
          end else if (char_i == CH_SP || char_i == CH_TAB ||
                       char_i == CH_LF || char_i == CH_CR) begin
            flush_c = 1'b1;
          end else begin
            add_a = 1'b1;
          end
        end
      endcase
    end
  end

  // Result assembly
  always_comb begin
    bat        = '0;
    mode_d     = mode_c;
    forced_d   = forced_c;
    nonempty_d = nonempty_q;
    cnt_d      = cnt_q;
    if (add_a) begin
      bat.ev[bat.n[1:0]] = '{kind: KIND_BYTE, ch: byte_a, cnt: cnt_report(cnt_d), last: 1'b0};
      bat.n              = bat.n + 1'b1;
      nonempty_d         = 1'b1;
    end
    if (add_b) begin
      bat.ev[bat.n[1:0]] = '{kind: KIND_BYTE, ch: byte_b, cnt: cnt_report(cnt_d), last: 1'b0};
      bat.n              = bat.n + 1'b1;
    end
    if ((flush_c || eol_i) && (forced_d || nonempty_d)) begin
      if (cnt_d != '1) begin
        cnt_d = cnt_d + 1'b1;
      end
      forced_d           = 1'b0;
      nonempty_d         = 1'b0;
      bat.ev[bat.n[1:0]] = '{kind: KIND_END, ch: 8'h00, cnt: cnt_report(cnt_d), last: 1'b0};
      bat.n              = bat.n + 1'b1;
    end
    if (eol_i) begin
      bat.ev[bat.n[1:0]] = '{kind: KIND_DONE, ch: 8'h00, cnt: cnt_report(cnt_d), last: 1'b0};
      bat.n              = bat.n + 1'b1;
      mode_d             = MODE_NORMAL;
      forced_d           = 1'b0;
      nonempty_d         = 1'b0;
      cnt_d              = '0;
    end
    if (bat.n != '0) begin
      bat.ev[2'(bat.n - 1'b1)].last = 1'b1;
    end
  end

  assign batch_o = bat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_NORMAL;
      forced_q   <= 1'b0;
      nonempty_q <= 1'b0;
      cnt_q      <= '0;
    end else if (commit_i) begin
      mode_q     <= mode_d;
      forced_q   <= forced_d;
      nonempty_q <= nonempty_d;
      cnt_q      <= cnt_d;
    end
  end

  // End of line returns the lexer to its reset state
  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && eol_i |=> cnt_q == '0 && mode_q == MODE_NORMAL && !forced_q && !nonempty_q)
    else $error("lexer state not cleared after end of line");

  // Inside skip mode only end of line produces results
  a_skip_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_SKIP && !eol_i |-> batch_o.n == '0)
    else $error("results produced while skipping after NUL");

  // A committed batch never overflows its slots
  a_batch_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i |-> batch_o.n <= RES_CNT_W'(MAX_RES))
    else $error("batch larger than the result slots");

endmodule

[rtl/quoted_token_splitter_top.sv]
// ----------------------------------------------------------------------------
// quoted_token_splitter_top
// Splits a line, one byte per transaction, into shell-style tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one byte of a line and an
//   end_of_line flag on the final byte. Output channel (out_valid_o /
//   out_stall_i) carries results: token bytes, token ends and one line-done
//   result with the token count; last_o flags the final result of each byte.
//   A byte sits in an input register while the lexer decodes it; its results
//   (0 to 4) are loaded into a four-slot result register and leave one per
//   cycle unless the receiver stalls. The first result is valid once the byte's
//   batch is loaded. Throughput is one byte per cycle while each byte causes at
//   most one result and the receiver does not stall; a byte with several
//   results holds back the next byte that has results until its own drain.
//   Bytes that cause no result pass even while results drain.
//   When the receiver stalls, the result register holds and the input stalls
//   once the pending byte has results and the slots are still occupied.
//   Reset clears the lexer state, token count and all valid flags.
// ----------------------------------------------------------------------------
module quoted_token_splitter_top import qts_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_in_i,
  input  logic        end_of_line_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  char_out_o,
  output logic [15:0] tokens_so_far_o,
  output logic        last_o
);

  logic       vin_q;
  logic [7:0] char_q;
  logic       eol_q;

  res_t [MAX_RES-1:0]   ev_q;
  logic [RES_CNT_W-1:0] bcnt_q;

  batch_t res;
  logic   out_take, batch_free, commit;

  qts_lexer #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_lexer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .commit_i(commit),
    .char_i  (char_q),
    .eol_i   (eol_q),
    .batch_o (res)
  );

  assign out_valid_o = (bcnt_q != '0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign batch_free  = (bcnt_q == '0) || (bcnt_q == RES_CNT_W'(1) && out_take);
  assign commit      = vin_q && (res.n == '0 || batch_free);
  assign in_stall_o  = vin_q && !commit;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q <= 1'b0;
    end else if (!in_stall_o) begin
      vin_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= char_in_i;
      eol_q  <= end_of_line_i;
    end
  end

  // Result slots: load a fresh batch, or advance to the next slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= '0;
    end else if (commit && res.n != '0) begin
      bcnt_q <= res.n;
    end else if (out_take) begin
      bcnt_q <= bcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && res.n != '0) begin
      ev_q <= res.ev;
    end else if (out_take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ev_q[i] <= ev_q[i+1];
      end
    end
  end

  assign kind_o          = ev_q[0].kind;
  assign char_out_o      = ev_q[0].ch;
  assign tokens_so_far_o = ev_q[0].cnt;
  assign last_o          = ev_q[0].last;

  a_last_matches_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (bcnt_q == RES_CNT_W'(1))))
    else $error("last flag does not match the final slot");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && res.n != '0 |-> batch_free)
    else $error("batch loaded over pending results");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> vin_q && res.n != '0 && !batch_free)
    else $error("input stalled without a blocked transaction");

endmodule

[tb/quoted_token_splitter_top_tb.sv]
// ----------------------------------------------------------------------------
// quoted_token_splitter_top_tb
// Self-checking bench for the shell-style token splitter. Lines of bytes go
// in through a valid/stall driver; a predictor tracks the quoting mode and
// token count and queues the token bytes, token ends and line-done results
// each byte should cause; a monitor checks every result in order. Stimulus
// runs a short directed set, then random lines (mostly well formed, some
// noisy), with random idling on both sides, a stretch without idling and a
// long receiver hold-off.
// ----------------------------------------------------------------------------
module quoted_token_splitter_top_tb import qts_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COUNT_W      = COUNT_WIDTH_DEF;
  localparam int unsigned IDLE_PCT     = 13;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LIMIT_CYCLES = 20_000;
  localparam int unsigned PHASE_ITEMS  = 24;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } byte_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  char_in_i;
  logic        end_of_line_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  char_out_o;
  logic [15:0] tokens_so_far_o;
  logic        last_o;

  byte_item_t  line_bytes [$];   // bytes waiting to be offered
  res_t        due_events [$];   // results still owed by the block
  res_t        step_events [$];  // results of the byte being predicted

  // predictor state
  mode_e           scan_mode;
  logic            quote_forced;
  logic            token_open;
  longint unsigned line_tokens;

  int unsigned err_count;
  int unsigned cycle_count;
  bit          byte_taken;
  bit          calm;
  bit          hold_arm;
  int unsigned hold_left;

  quoted_token_splitter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_in_i       (char_in_i),
    .end_of_line_i   (end_of_line_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .char_out_o      (char_out_o),
    .tokens_so_far_o (tokens_so_far_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_separator(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function void clear_line_state();
    scan_mode    = MODE_NORMAL;
    quote_forced = 1'b0;
    token_open   = 1'b0;
    line_tokens  = 0;
  endfunction

  function void emit(kind_e k, logic [7:0] ch);
    res_t r;
    r.kind = k;
    r.ch   = ch;
    r.cnt  = (line_tokens > 64'hFFFF) ? 16'hFFFF : line_tokens[15:0];
    r.last = 1'b0;
    step_events.push_back(r);
  endfunction

  function void append_byte(logic [7:0] ch);
    token_open = 1'b1;
    emit(KIND_BYTE, ch);
  endfunction

  function void close_token();
    if (quote_forced || token_open) begin
      if (line_tokens < ((64'd1 << COUNT_W) - 1)) line_tokens++;
      quote_forced = 1'b0;
      token_open   = 1'b0;
      emit(KIND_END, 8'h00);
    end
  endfunction

  function void split_byte(logic [7:0] c, logic eol);
    step_events.delete();
    if (c == CH_NUL) begin
      if (scan_mode != MODE_SKIP) close_token();
      scan_mode = MODE_SKIP;
    end else begin
      case (scan_mode)
        MODE_ESC: begin
          append_byte(c);
          scan_mode = MODE_NORMAL;
        end
        MODE_DQ: begin
          if (c == CH_BSL) scan_mode = MODE_DQ_ESC;
          else if (c == CH_DQ) scan_mode = MODE_NORMAL;
          else append_byte(c);
        end
        MODE_DQ_ESC: begin
          // keep the backslash unless it escapes one of the three specials
          if (c != CH_DOLLAR && c != CH_BSL && c != CH_DQ) append_byte(CH_BSL);
          append_byte(c);
          scan_mode = MODE_DQ;
        end
        MODE_SQ: begin
          if (c == CH_SQ) scan_mode = MODE_NORMAL;
          else append_byte(c);
        end
        MODE_SKIP: ;
        default: begin
          scan_mode = MODE_NORMAL;
          if (c == CH_BSL) begin
            scan_mode = MODE_ESC;
          end else if (c == CH_DQ) begin
            quote_forced = 1'b1;
            scan_mode    = MODE_DQ;
          end else if (c == CH_SQ) begin
            quote_forced = 1'b1;
            scan_mode    = MODE_SQ;
          end else if (is_separator(c)) begin
            close_token();
          end else begin
            append_byte(c);
          end
        end
      endcase
    end
    if (eol) begin
      close_token();
      emit(KIND_DONE, 8'h00);
      clear_line_state();
    end
    if (step_events.size() != 0) step_events[step_events.size()-1].last = 1'b1;
    foreach (step_events[i]) due_events.push_back(step_events[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == CH_BSL || c == CH_DQ || c == CH_SQ || is_separator(c));
    return c;
  endfunction

  function automatic logic [7:0] separator_char();
    case ($urandom_range(0, 3))
      0:       return CH_SP;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  task automatic queue_random_line(input bit noisy);
    byte_item_t line [$];
    int n_tok;
    int n_part;
    int n_fill;
    int t;
    int p;
    int k;
    logic [7:0] c;
    n_tok = $urandom_range(1, 5);
    if ($urandom_range(0, 3) == 0) line.push_back('{separator_char(), 1'b0});
    for (t = 0; t < n_tok; t++) begin
      n_part = $urandom_range(1, 3);
      for (p = 0; p < n_part; p++) begin
        case ($urandom_range(0, 5))
          0, 1: begin
            n_fill = $urandom_range(1, 3);
            for (k = 0; k < n_fill; k++) line.push_back('{plain_char(), 1'b0});
          end
          2: begin
            line.push_back('{CH_BSL, 1'b0});
            line.push_back('{8'($urandom_range(1, 255)), 1'b0});
          end
          3: begin
            line.push_back('{CH_DQ, 1'b0});
            n_fill = $urandom_range(0, 3);
            for (k = 0; k < n_fill; k++) begin
              if ($urandom_range(0, 2) == 0) begin
                line.push_back('{CH_BSL, 1'b0});
                case ($urandom_range(0, 3))
                  0:       c = CH_DOLLAR;
                  1:       c = CH_BSL;
                  2:       c = CH_DQ;
                  default: c = 8'($urandom_range(1, 255));
                endcase
              end else begin
                do c = 8'($urandom_range(1, 255));
                while (c == CH_DQ || c == CH_BSL);
              end
              line.push_back('{c, 1'b0});
            end
            // leave the quote open now and then
            if (!(noisy && $urandom_range(0, 3) == 0)) line.push_back('{CH_DQ, 1'b0});
          end
          4: begin
            line.push_back('{CH_SQ, 1'b0});
            n_fill = $urandom_range(0, 3);
            for (k = 0; k < n_fill; k++) begin
              do c = 8'($urandom_range(1, 255));
              while (c == CH_SQ);
              line.push_back('{c, 1'b0});
            end
            if (!(noisy && $urandom_range(0, 3) == 0)) line.push_back('{CH_SQ, 1'b0});
          end
          default: begin
            c = noisy ? 8'($urandom_range(0, 255)) : plain_char();
            line.push_back('{c, 1'b0});
          end
        endcase
      end
      if (t != n_tok - 1 || $urandom_range(0, 1) == 0) begin
        line.push_back('{separator_char(), 1'b0});
        if ($urandom_range(0, 3) == 0) line.push_back('{separator_char(), 1'b0});
      end
    end
    line[line.size()-1].eol = 1'b1;
    foreach (line[i]) line_bytes.push_back(line[i]);
  endtask

  task automatic queue_random_phase();
    while (line_bytes.size() < PHASE_ITEMS) queue_random_line($urandom_range(0, 3) == 0);
  endtask

  task automatic wait_bytes_sent();
    while (line_bytes.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      byte_taken = 1'b0;
      if (line_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid_i    <= 1'b1;
        char_in_i     <= line_bytes[0].ch;
        end_of_line_i <= line_bytes[0].eol;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or a long hold-off once armed
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_arm) begin
      hold_arm  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        split_byte(char_in_i, end_of_line_i);
        void'(line_bytes.pop_front());
        byte_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (due_events.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result: expected none, %s", $time,
                   $sformatf("got kind=%0d char=%02h count=%0d last=%0b",
                             kind_o, char_out_o, tokens_so_far_o, last_o));
        end else begin
          want = due_events.pop_front();
          if (kind_o !== want.kind || char_out_o !== want.ch ||
              tokens_so_far_o !== want.cnt || last_o !== want.last) begin
            err_count++;
            $display("%0t: result mismatch: expected kind=%0d char=%02h count=%0d last=%0b, %s",
                     $time, want.kind, want.ch, want.cnt, want.last,
                     $sformatf("got kind=%0d char=%02h count=%0d last=%0b",
                               kind_o, char_out_o, tokens_so_far_o, last_o));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("quoted_token_splitter_top_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    logic [8:0] opening [$];
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    char_in_i     = 8'h00;
    end_of_line_i = 1'b0;
    out_stall_i   = 1'b0;
    err_count     = 0;
    cycle_count   = 0;
    byte_taken    = 1'b0;
    calm          = 1'b0;
    hold_arm      = 1'b0;
    hold_left     = 0;
    clear_line_state();

    // {end_of_line, byte}
    opening = '{
      {1'b0, "a"},    {1'b0, CH_SP},  {1'b0, CH_BSL}, {1'b0, CH_SP},
      {1'b0, CH_DQ},  {1'b0, CH_BSL}, {1'b0, CH_DOLLAR},
      {1'b0, CH_BSL}, {1'b0, "n"},    {1'b0, CH_DQ},
      {1'b0, CH_SQ},  {1'b0, CH_BSL}, {1'b0, CH_SQ},  {1'b0, CH_TAB},
      {1'b0, CH_DQ},  {1'b0, CH_DQ},  {1'b0, CH_CR},  {1'b1, CH_SQ},
      {1'b1, CH_BSL},
      {1'b0, "x"},    {1'b0, CH_NUL}, {1'b0, "y"},    {1'b1, CH_LF},
      {1'b0, CH_DQ},  {1'b0, CH_BSL}, {1'b1, 8'hFF},
      {1'b0, CH_DQ},  {1'b1, CH_BSL}
    };

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening[j]) line_bytes.push_back('{opening[j][7:0], opening[j][8]});
    wait_bytes_sent();

    queue_random_phase();
    wait_bytes_sent();

    calm = 1'b1;
    queue_random_phase();
    wait_bytes_sent();
    calm = 1'b0;

    // hold the output long enough for the block to back up into its input
    hold_arm = 1'b1;
    queue_random_phase();
    wait_bytes_sent();

    while (due_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("quoted_token_splitter_top_tb: clean");
    end else begin
      $display("quoted_token_splitter_top_tb: errors");
    end
    $finish;
  end

endmodule
